@@ src/fce_pkg.sv @@
// Shared types and constants of the fire cell event engine.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package fce_pkg;

  // Field widths of the words on the channels.
  localparam int CELL_IDX_W = 12;
  localparam int KIND_W     = 2;
  localparam int AMOUNT_W   = 16;
  localparam int TIME_W     = 32;
  localparam int LEVEL_W    = 8;
  localparam int MASK_W     = 8;
  localparam int GRID_W     = 7;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROWTH_RATE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIATED_FRC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BURNOUT_LVL  = 3'd4;

  localparam logic [GRID_W-1:0]     GRID_WIDTH_RST   = 7'd64;
  localparam logic [GRID_W-1:0]     GRID_HEIGHT_RST  = 7'd64;
  localparam logic [CFG_DATA_W-1:0] GROWTH_RATE_RST  = 16'd15;
  localparam logic [CFG_DATA_W-1:0] RADIATED_FRC_RST = 16'd3277;
  localparam logic [CFG_DATA_W-1:0] BURNOUT_LVL_RST  = 16'd20;

  // Event timing.
  localparam logic [TIME_W-1:0] IGN_DELAY   = 32'd1;
  localparam logic [TIME_W-1:0] RAD_DELAY   = 32'd1;
  localparam logic [TIME_W-1:0] REARM_DELAY = 32'd5;
  localparam int                PEAK_RATIO  = 2;

  // Ignition-to-peak heat gap is threshold times (PEAK_RATIO - 1).
  localparam int GAP_W = LEVEL_W + $clog2(PEAK_RATIO);

  // Shared divider: cell index by grid width, heat gap by growth rate.
  localparam int DIV_W     = CELL_IDX_W;
  localparam int DIVISOR_W = 16;

  typedef enum logic [KIND_W-1:0] {
    K_RAD   = 2'd0,
    K_TIMER = 2'd1,
    K_IGN   = 2'd2,
    K_PEAK  = 2'd3
  } kind_e;

  // Cell burn status codes; code three is never written.
  localparam logic [1:0] ST_UNBURNT = 2'd0;
  localparam logic [1:0] ST_BURNING = 2'd1;
  localparam logic [1:0] ST_BURNT   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_UPDATE,
    S_DIV,
    S_SCAN,
    S_FINAL
  } state_e;

  typedef struct packed {
    logic latch;
    logic check;
    logic mul;
    logic update;
    logic div_finish;
    logic emit_rad;
    logic scan_adv;
    logic emit_pend;
  } dp_cmd_t;

  typedef struct packed {
    logic  in_range;
    logic  is_load;
    kind_e kind;
    logic  fire;
    logic  div_done;
    logic  link_set;
    logic  scan_last;
    logic  burnt;
    logic  out_free;
  } dp_status_t;

endpackage

@@ src/fce_if.sv @@
// Valid/ready channel interfaces for input items and result words.
// Depends on fce_pkg for the field widths.
`timescale 1ns / 1ps

interface fce_in_if;
  import fce_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [CELL_IDX_W-1:0] cell_index;
  logic [KIND_W-1:0]     event_kind;
  logic [AMOUNT_W-1:0]   heat_amount;
  logic [TIME_W-1:0]     event_time;
  logic [LEVEL_W-1:0]    ignition_level;
  logic [MASK_W-1:0]     neighbor_mask;

  modport source (output valid, command, cell_index, event_kind, heat_amount,
                  event_time, ignition_level, neighbor_mask, input ready);
  modport sink (input valid, command, cell_index, event_kind, heat_amount,
                event_time, ignition_level, neighbor_mask, output ready);
endinterface

interface fce_out_if;
  import fce_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CELL_IDX_W-1:0] dest_cell;
  logic [KIND_W-1:0]     out_kind;
  logic [AMOUNT_W-1:0]   out_heat;
  logic [TIME_W-1:0]     out_time;
  logic                  last_of_run;

  modport source (output valid, dest_cell, out_kind, out_heat, out_time,
                  last_of_run, input ready);
  modport sink (input valid, dest_cell, out_kind, out_heat, out_time,
                last_of_run, output ready);
endinterface

@@ src/fce_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on fce_pkg for its widths.
`timescale 1ns / 1ps

module fce_div import fce_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_W-1:0]     dividend_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  output logic                 done_o,
  output logic [DIV_W-1:0]     quotient_o,
  output logic [DIVISOR_W-1:0] remainder_o
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0]     count_q, count_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] dvs_q, dvs_d;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  always_comb begin
    trial   = {rem_q, quo_q[DIV_W-1]};
    fits    = trial >= {1'b0, dvs_q};
    count_d = count_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      count_d = CNT_W'(DIV_W);
      quo_d   = dividend_i;
      rem_d   = '0;
      dvs_d   = divisor_i;
    end else if (count_q != '0) begin
      count_d = count_q - CNT_W'(1);
      quo_d   = {quo_q[DIV_W-2:0], fits};
      rem_d   = fits ? DIVISOR_W'(trial - {1'b0, dvs_q}) : trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = count_q == '0;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

@@ src/fce_ctrl.sv @@
// Sequencer of the fire cell event engine: one item at a time.
// Depends on fce_pkg for the state, command and status types.
`timescale 1ns / 1ps

module fce_ctrl import fce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!status_i.in_range) begin
          state_d = S_IDLE;
        end else if (status_i.is_load) begin
          state_d = status_i.fire ? S_FINAL : S_IDLE;
        end else begin
          unique case (status_i.kind)
            K_RAD:   state_d = status_i.fire ? S_FINAL : S_IDLE;
            K_TIMER: state_d = S_MUL;
            K_IGN:   state_d = S_DIV;
            K_PEAK:  state_d = S_FINAL;
          endcase
        end
      end
      S_MUL:    state_d = S_UPDATE;
      S_UPDATE: state_d = S_DIV;
      S_DIV: begin
        if (status_i.div_done) state_d = (status_i.kind == K_TIMER) ? S_SCAN : S_FINAL;
      end
      S_SCAN: begin
        if ((!status_i.link_set || status_i.out_free) && status_i.scan_last) begin
          state_d = status_i.burnt ? S_IDLE : S_FINAL;
        end
      end
      S_FINAL: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    in_ready_o       = state_q == S_IDLE;
    cmd_o.latch      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.check      = state_q == S_CHECK;
    cmd_o.mul        = state_q == S_MUL;
    cmd_o.update     = state_q == S_UPDATE;
    cmd_o.div_finish = (state_q == S_DIV) && status_i.div_done;
    cmd_o.emit_rad   = (state_q == S_SCAN) && status_i.link_set && status_i.out_free;
    cmd_o.scan_adv   = (state_q == S_SCAN) && (!status_i.link_set || status_i.out_free);
    cmd_o.emit_pend  = (state_q == S_FINAL) && status_i.out_free;
  end

endmodule

@@ src/fce_dp.sv @@
// Datapath: configuration registers, cell memory, timer arithmetic, divider
// and the output register. Depends on fce_pkg and fce_div.
`timescale 1ns / 1ps

module fce_dp import fce_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64,
  parameter int HEAT_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_command_i,
  input  logic [CELL_IDX_W-1:0] in_cell_index_i,
  input  logic [KIND_W-1:0]     in_event_kind_i,
  input  logic [AMOUNT_W-1:0]   in_heat_amount_i,
  input  logic [TIME_W-1:0]     in_event_time_i,
  input  logic [LEVEL_W-1:0]    in_ignition_level_i,
  input  logic [MASK_W-1:0]     in_neighbor_mask_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [CELL_IDX_W-1:0] out_dest_cell_o,
  output logic [KIND_W-1:0]     out_kind_o,
  output logic [AMOUNT_W-1:0]   out_heat_o,
  output logic [TIME_W-1:0]     out_time_o,
  output logic                  out_last_of_run_o
);

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ENTRY_W    = HEAT_BITS + 2 + LEVEL_W + MASK_W;
  localparam int PROD_W     = HEAT_BITS + 16;
  localparam logic [32:0] HEAT_MAX33 = (33'd1 << HEAT_BITS) - 33'd1;

  function automatic logic [HEAT_BITS-1:0] sat_heat(input logic [32:0] v);
    logic [32:0] s;
    s = (v > HEAT_MAX33) ? HEAT_MAX33 : v;
    return s[HEAT_BITS-1:0];
  endfunction

  // Configuration registers.
  logic [GRID_W-1:0]     gw_q, gh_q;
  logic [CFG_DATA_W-1:0] growth_q, frac_q, burn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q     <= GRID_WIDTH_RST;
      gh_q     <= GRID_HEIGHT_RST;
      growth_q <= GROWTH_RATE_RST;
      frac_q   <= RADIATED_FRC_RST;
      burn_q   <= BURNOUT_LVL_RST;
    end else if (cfg_we_i) begin
      priority case (cfg_index_i)
        CFG_GRID_WIDTH:   gw_q     <= cfg_data_i[GRID_W-1:0];
        CFG_GRID_HEIGHT:  gh_q     <= cfg_data_i[GRID_W-1:0];
        CFG_GROWTH_RATE:  growth_q <= cfg_data_i;
        CFG_RADIATED_FRC: frac_q   <= cfg_data_i;
        CFG_BURNOUT_LVL:  burn_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [GRID_W-1:0]     w_eff, h_eff;
  logic [CFG_DATA_W-1:0] growth_eff;
  logic [2*GRID_W-1:0]   cells_used;
  logic                  in_range_d;

  always_comb begin
    if (gw_q == '0) w_eff = GRID_W'(1);
    else if (11'(gw_q) > 11'(MAX_COLUMNS)) w_eff = GRID_W'(MAX_COLUMNS);
    else w_eff = gw_q;
    if (gh_q == '0) h_eff = GRID_W'(1);
    else if (11'(gh_q) > 11'(MAX_ROWS)) h_eff = GRID_W'(MAX_ROWS);
    else h_eff = gh_q;
    growth_eff = (growth_q == '0) ? CFG_DATA_W'(1) : growth_q;
    cells_used = (2*GRID_W)'(w_eff) * (2*GRID_W)'(h_eff);
    in_range_d = (32'(in_cell_index_i) < 32'(cells_used)) &&
                 (32'(in_cell_index_i) < 32'(CELL_COUNT));
  end

  // Latched input item.
  logic                  cmd_q, inr_q;
  logic [CELL_IDX_W-1:0] idx_q;
  kind_e                 kind_q;
  logic [AMOUNT_W-1:0]   amt_q;
  logic [TIME_W-1:0]     time_q;
  logic [LEVEL_W-1:0]    lvl_q;
  logic [MASK_W-1:0]     mask_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q  <= in_command_i;
      inr_q  <= in_range_d;
      idx_q  <= in_cell_index_i;
      kind_q <= kind_e'(in_event_kind_i);
      amt_q  <= in_heat_amount_i;
      time_q <= in_event_time_i;
      lvl_q  <= in_ignition_level_i;
      mask_q <= in_neighbor_mask_i;
    end
  end

  // Cell memory: heat, status, threshold, links.
  logic [ENTRY_W-1:0] mem [CELL_COUNT];
  logic [ENTRY_W-1:0] rd_q, wr_data;
  logic               wr_en;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) rd_q <= mem[ADDR_W'(in_cell_index_i)];
    if (wr_en) mem[ADDR_W'(idx_q)] <= wr_data;
  end

  logic [HEAT_BITS-1:0] heat_rd, heat_ld, heat_rad, heat_pk, heat_tm, rad_r;
  logic [1:0]           status_rd;
  logic [LEVEL_W-1:0]   thr_rd;
  logic [MASK_W-1:0]    links_rd;
  logic [GAP_W-1:0]     gap;
  logic                 fire, burnt_d;
  logic [32:0]          r_eighth;
  logic [AMOUNT_W-1:0]  share_d;
  logic [PROD_W-1:0]    prod_q;

  assign heat_rd   = rd_q[ENTRY_W-1 -: HEAT_BITS];
  assign status_rd = rd_q[LEVEL_W+MASK_W+1 -: 2];
  assign thr_rd    = rd_q[LEVEL_W+MASK_W-1 -: LEVEL_W];
  assign links_rd  = rd_q[MASK_W-1:0];

  always_comb begin
    gap      = GAP_W'(32'(thr_rd) * (PEAK_RATIO - 1));
    heat_ld  = sat_heat(33'(amt_q));
    heat_rad = sat_heat(33'(heat_rd) + 33'(amt_q));
    heat_pk  = sat_heat(33'(heat_rd) + 33'(gap));
    if (cmd_q) fire = 33'(heat_ld) >= 33'(lvl_q);
    else fire = (status_rd == ST_UNBURNT) && (33'(heat_rad) >= 33'(thr_rd));
    rad_r    = prod_q[PROD_W-1:16];
    heat_tm  = heat_rd - rad_r;
    burnt_d  = 33'(heat_tm) <= 33'(burn_q);
    r_eighth = 33'(rad_r >> 3);
    share_d  = (r_eighth > 33'd65535) ? 16'hFFFF : r_eighth[AMOUNT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) prod_q <= PROD_W'(heat_rd) * PROD_W'(frac_q);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = rd_q;
    if (cmd_i.check && inr_q) begin
      if (cmd_q) begin
        wr_en   = 1'b1;
        wr_data = {heat_ld, ST_UNBURNT, lvl_q, mask_q};
      end else begin
        unique case (kind_q)
          K_RAD: begin
            wr_en   = status_rd != ST_BURNT;
            wr_data = {heat_rad, status_rd, thr_rd, links_rd};
          end
          K_IGN: begin
            wr_en   = 1'b1;
            wr_data = {heat_rd, ST_BURNING, thr_rd, links_rd};
          end
          K_PEAK: begin
            wr_en   = 1'b1;
            wr_data = {heat_pk, status_rd, thr_rd, links_rd};
          end
          K_TIMER: ;
        endcase
      end
    end else if (cmd_i.update) begin
      wr_en   = 1'b1;
      wr_data = {heat_tm, burnt_d ? ST_BURNT : status_rd, thr_rd, links_rd};
    end
  end

  // Divider: heat gap by growth rate on ignition, index by width on a timer.
  logic                 div_start, div_done;
  logic [DIV_W-1:0]     div_dividend, div_quo;
  logic [DIVISOR_W-1:0] div_divisor, div_rem;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_W'(idx_q);
    div_divisor  = DIVISOR_W'(w_eff);
    if (cmd_i.check && inr_q && !cmd_q && kind_q == K_IGN) begin
      div_start    = 1'b1;
      div_dividend = DIV_W'(gap);
      div_divisor  = growth_eff;
    end else if (cmd_i.update) begin
      div_start = 1'b1;
    end
  end

  fce_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Final result of the run, and the timer's scan state.
  kind_e               pend_kind_q;
  logic [TIME_W-1:0]   pend_time_q;
  logic                burnt_q;
  logic [AMOUNT_W-1:0] share_q;
  logic [GRID_W-1:0]   col_q, row_q;
  logic [2:0]          d_q, top_link;

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      if (cmd_q) begin
        pend_kind_q <= K_IGN;
        pend_time_q <= IGN_DELAY;
      end else if (kind_q == K_PEAK) begin
        pend_kind_q <= K_TIMER;
        pend_time_q <= time_q;
      end else begin
        pend_kind_q <= K_IGN;
        pend_time_q <= time_q + IGN_DELAY;
      end
    end
    if (cmd_i.update) begin
      pend_kind_q <= K_TIMER;
      pend_time_q <= time_q + REARM_DELAY;
      burnt_q     <= burnt_d;
      share_q     <= share_d;
    end
    if (cmd_i.div_finish) begin
      if (kind_q == K_IGN) begin
        pend_kind_q <= K_PEAK;
        pend_time_q <= time_q + TIME_W'(div_quo);
      end
      col_q <= div_rem[GRID_W-1:0];
      row_q <= div_quo[GRID_W-1:0];
      d_q   <= 3'd0;
    end else if (cmd_i.scan_adv) begin
      d_q <= d_q + 3'd1;
    end
  end

  // Neighbor of the cell in direction d on the wrapped grid.
  logic [GRID_W-1:0]     col_p, col_m, row_p, row_m, nc, nr;
  logic [CELL_IDX_W-1:0] nbr_cell;

  always_comb begin
    col_p = (col_q == w_eff - GRID_W'(1)) ? '0 : col_q + GRID_W'(1);
    col_m = (col_q == '0) ? w_eff - GRID_W'(1) : col_q - GRID_W'(1);
    row_p = (row_q == h_eff - GRID_W'(1)) ? '0 : row_q + GRID_W'(1);
    row_m = (row_q == '0) ? h_eff - GRID_W'(1) : row_q - GRID_W'(1);
    unique case (d_q)
      3'd0: begin nc = col_q; nr = row_m; end
      3'd1: begin nc = col_p; nr = row_m; end
      3'd2: begin nc = col_p; nr = row_q; end
      3'd3: begin nc = col_p; nr = row_p; end
      3'd4: begin nc = col_q; nr = row_p; end
      3'd5: begin nc = col_m; nr = row_p; end
      3'd6: begin nc = col_m; nr = row_q; end
      3'd7: begin nc = col_m; nr = row_m; end
    endcase
    nbr_cell = CELL_IDX_W'((2*GRID_W)'(nc) + (2*GRID_W)'(nr) * (2*GRID_W)'(w_eff));
  end

  always_comb begin
    top_link = 3'd0;
    for (int i = 0; i < MASK_W; i++) begin
      if (links_rd[i]) top_link = 3'(i);
    end
  end

  // Output register.
  logic                  out_valid_q;
  logic [CELL_IDX_W-1:0] out_dest_q;
  kind_e                 out_kind_q;
  logic [AMOUNT_W-1:0]   out_heat_q;
  logic [TIME_W-1:0]     out_time_q;
  logic                  out_last_q;
  logic                  out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_rad || cmd_i.emit_pend) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_rad) begin
      out_dest_q <= nbr_cell;
      out_kind_q <= K_RAD;
      out_heat_q <= share_q;
      out_time_q <= time_q + RAD_DELAY;
      out_last_q <= burnt_q && (d_q == top_link);
    end else if (cmd_i.emit_pend) begin
      out_dest_q <= idx_q;
      out_kind_q <= pend_kind_q;
      out_heat_q <= '0;
      out_time_q <= pend_time_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_dest_cell_o   = out_dest_q;
  assign out_kind_o        = out_kind_q;
  assign out_heat_o        = out_heat_q;
  assign out_time_o        = out_time_q;
  assign out_last_of_run_o = out_last_q;

  always_comb begin
    status_o.in_range  = inr_q;
    status_o.is_load   = cmd_q;
    status_o.kind      = kind_q;
    status_o.fire      = fire;
    status_o.div_done  = div_done;
    status_o.link_set  = links_rd[d_q];
    status_o.scan_last = d_q == 3'd7;
    status_o.burnt     = burnt_q;
    status_o.out_free  = out_free;
  end

endmodule

@@ src/fire_cell_event_engine.sv @@
// Fire cell event engine, top level: one input item at a time. A load or a
// delivered event is latched and its cell entry is read from a single-port
// cell memory (one read in the accept cycle, one write later). An item with
// a single result emits it in a final step that waits while the output
// register is full. An ignition adds a pass of the bit-serial divider that
// works out the time to peak. A radiation timer takes a multiply step, an
// update step, the divider pass that splits the index into column and row,
// then a scan of the neighbor directions (eight), which also waits at the
// output, and a final step for the re-armed timer unless the cell burnt out.
// Results leave through an output register, so the next item is taken while
// the last word of a run still waits. The cell memory has no clearing pass:
// a cell that was never loaded holds no defined contents.
// Depends on fce_pkg, fce_if, fce_ctrl and fce_dp.
`timescale 1ns / 1ps

module fire_cell_event_engine import fce_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64,
  parameter int HEAT_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fce_in_if.sink                in_s,
  fce_out_if.source             out_s,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller sequences each item; the datapath holds all storage.
  fce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_s.valid),
    .in_ready_o (in_s.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fce_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .HEAT_BITS   (HEAT_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_command_i        (in_s.command),
    .in_cell_index_i     (in_s.cell_index),
    .in_event_kind_i     (in_s.event_kind),
    .in_heat_amount_i    (in_s.heat_amount),
    .in_event_time_i     (in_s.event_time),
    .in_ignition_level_i (in_s.ignition_level),
    .in_neighbor_mask_i  (in_s.neighbor_mask),
    .cmd_i               (cmd),
    .status_o            (status),
    .out_ready_i         (out_s.ready),
    .out_valid_o         (out_s.valid),
    .out_dest_cell_o     (out_s.dest_cell),
    .out_kind_o          (out_s.out_kind),
    .out_heat_o          (out_s.out_heat),
    .out_time_o          (out_s.out_time),
    .out_last_of_run_o   (out_s.last_of_run)
  );

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the fire cell event engine: directed and random items
// through the valid/ready channels, results checked against an in-bench predictor.
// Depends on fce_pkg, fce_if and the fire_cell_event_engine top level.
`timescale 1ns / 1ps

module tb;
  import fce_pkg::*;

  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS_P = 64;
  localparam int CELLS      = MAX_COLS * MAX_ROWS_P;
  localparam int HEAT_TOP   = 65535;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PER_PHASE = 60;

  typedef struct {
    bit                  load;
    bit [CELL_IDX_W-1:0] idx;
    kind_e               kind;
    bit [AMOUNT_W-1:0]   amount;
    bit [TIME_W-1:0]     stamp;
    bit [LEVEL_W-1:0]    level;
    bit [MASK_W-1:0]     mask;
  } cell_item_t;

  typedef struct packed {
    bit [CELL_IDX_W-1:0] dest;
    bit [KIND_W-1:0]     kind;
    bit [AMOUNT_W-1:0]   heat;
    bit [TIME_W-1:0]     stamp;
    bit                  last;
  } fire_event_t;

  // Scoreboard: keeps a private copy of the grid and turns each accepted item
  // into the events the engine should emit, in order.
  class fire_scoreboard;
    bit [15:0] heat[CELLS];
    bit [1:0]  status[CELLS];
    bit [7:0]  thresh[CELLS];
    bit [7:0]  links[CELLS];
    bit        loaded[CELLS];
    int unsigned cols = 64, rows = 64;
    bit [15:0] growth = 15, frac = 3277, burnout = 20;
    fire_event_t pending_events[$];
    cell_item_t  followups[$];
    int mismatches;
    int words_checked;

    function void configure(bit [CFG_IDX_W-1:0] reg_idx, bit [CFG_DATA_W-1:0] val);
      case (reg_idx)
        CFG_GRID_WIDTH:   cols = (val[6:0] == 0) ? 1 :
                                 (val[6:0] > MAX_COLS) ? MAX_COLS : val[6:0];
        CFG_GRID_HEIGHT:  rows = (val[6:0] == 0) ? 1 :
                                 (val[6:0] > MAX_ROWS_P) ? MAX_ROWS_P : val[6:0];
        CFG_GROWTH_RATE:  growth = val;
        CFG_RADIATED_FRC: frac = val;
        CFG_BURNOUT_LVL:  burnout = val;
        default: ;
      endcase
      followups.delete();
    endfunction

    function bit [15:0] sat_add(bit [15:0] a, bit [16:0] b);
      bit [17:0] sum;
      sum = a + b;
      return (sum > HEAT_TOP) ? 16'hFFFF : sum[15:0];
    endfunction

    function void note_input(cell_item_t it);
      fire_event_t run[$];
      fire_event_t ev;
      cell_item_t fu;
      int dc[8] = '{0, 1, 1, 1, 0, -1, -1, -1};
      int dr[8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
      int i, col, row, nc, nr;
      bit [31:0] radiated;
      bit [8:0] gap;
      if (it.idx >= cols * rows) return;
      gap = 9'(thresh[it.idx] * (PEAK_RATIO - 1));
      ev = '{dest: it.idx, kind: K_IGN, heat: '0, stamp: '0, last: 1'b0};
      if (it.load) begin
        heat[it.idx] = it.amount;
        status[it.idx] = ST_UNBURNT;
        thresh[it.idx] = it.level;
        links[it.idx] = it.mask;
        loaded[it.idx] = 1'b1;
        if (it.amount >= it.level) begin
          ev.stamp = IGN_DELAY;
          run.insert(run.size(), ev);
        end
      end else begin
        case (it.kind)
          K_RAD: begin
            if (status[it.idx] != ST_BURNT) begin
              heat[it.idx] = sat_add(heat[it.idx], it.amount);
              if (status[it.idx] == ST_UNBURNT && heat[it.idx] >= thresh[it.idx]) begin
                ev.stamp = it.stamp + IGN_DELAY;
                run.insert(run.size(), ev);
              end
            end
          end
          K_TIMER: begin
            radiated = (32'(heat[it.idx]) * frac) >> 16;
            heat[it.idx] = heat[it.idx] - radiated[15:0];
            col = it.idx % cols;
            row = it.idx / cols;
            for (i = 0; i < 8; i++) begin
              if (links[it.idx][i]) begin
                nc = (col + dc[i] + cols) % cols;
                nr = (row + dr[i] + rows) % rows;
                run.insert(run.size(), '{dest: CELL_IDX_W'(nc + nr * cols), kind: K_RAD,
                                         heat: AMOUNT_W'(radiated >> 3),
                                         stamp: it.stamp + RAD_DELAY, last: 1'b0});
              end
            end
            if (heat[it.idx] <= burnout) begin
              status[it.idx] = ST_BURNT;
            end else begin
              ev.kind = K_TIMER;
              ev.stamp = it.stamp + REARM_DELAY;
              run.insert(run.size(), ev);
            end
          end
          K_IGN: begin
            status[it.idx] = ST_BURNING;
            ev.kind = K_PEAK;
            ev.stamp = it.stamp + gap / ((growth == 0) ? 1 : growth);
            run.insert(run.size(), ev);
          end
          default: begin
            heat[it.idx] = sat_add(heat[it.idx], gap);
            ev.kind = K_TIMER;
            ev.stamp = it.stamp;
            run.insert(run.size(), ev);
          end
        endcase
      end
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      foreach (run[j]) begin
        pending_events.insert(pending_events.size(), run[j]);
        // Emitted events become later stimulus, but only toward loaded cells.
        if (loaded[run[j].dest] && followups.size() < 64) begin
          fu = '{load: 1'b0, idx: run[j].dest, kind: kind_e'(run[j].kind),
                 amount: run[j].heat, stamp: run[j].stamp, level: 8'd1, mask: 8'd0};
          followups.insert(followups.size(), fu);
        end
      end
    endfunction

    function void check_result(fire_event_t got);
      fire_event_t want;
      words_checked++;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected word dest=%0d kind=%0d heat=%0d time=%0d last=%0b",
                   got.dest, got.kind, got.heat, got.stamp, got.last);
        return;
      end
      want = pending_events.pop_front();
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: word mismatch exp dest=%0d kind=%0d heat=%0d time=%0d ",
                    "last=%0b, got dest=%0d kind=%0d heat=%0d time=%0d last=%0b"},
                   want.dest, want.kind, want.heat, want.stamp, want.last,
                   got.dest, got.kind, got.heat, got.stamp, got.last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  fce_in_if  in_if ();
  fce_out_if out_if ();

  fire_cell_event_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (in_if),
    .out_s      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  fire_scoreboard sb = new();
  bit quiet;          // When set, neither side idles.
  int stall_cycles;
  int items_sent;
  int phases_run;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.command = 1'b0;
    in_if.cell_index = '0;
    in_if.event_kind = '0;
    in_if.heat_amount = '0;
    in_if.event_time = '0;
    in_if.ignition_level = '0;
    in_if.neighbor_mask = '0;
    out_if.ready = 1'b0;
  end

  // The receiver stalls at random, about one time in ten, unless the run is in a
  // quiet stretch.
  always @(posedge clk_i) begin
    out_if.ready <= quiet || ($urandom_range(99) >= 10);
  end

  // Monitor: both channels are sampled at the edge, before any driver
  // update of that edge lands. Output words are checked before the input word
  // of the same edge is predicted, since a result never leaves in the cycle its
  // input is taken.
  always @(posedge clk_i) begin
    fire_event_t got;
    cell_item_t  taken;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = '{dest: out_if.dest_cell, kind: out_if.out_kind, heat: out_if.out_heat,
                stamp: out_if.out_time, last: out_if.last_of_run};
        sb.check_result(got);
      end
      if (in_if.valid && in_if.ready) begin
        taken = '{load: in_if.command, idx: in_if.cell_index,
                  kind: kind_e'(in_if.event_kind), amount: in_if.heat_amount,
                  stamp: in_if.event_time, level: in_if.ignition_level,
                  mask: in_if.neighbor_mask};
        sb.note_input(taken);
      end
    end
  end

  // Watchdog: a long run of cycles with no word moving on either side means
  // the engine has hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("ERROR: watchdog expired with %0d words outstanding",
                 sb.pending_events.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Drives one item and holds it until the engine takes it. Valid stays high
  // afterwards, so a back-to-back item needs no second assignment in a step.
  task automatic send_item(cell_item_t it);
    if (!quiet && $urandom_range(99) < 10) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.command        <= it.load;
    in_if.cell_index     <= it.idx;
    in_if.event_kind     <= it.kind;
    in_if.heat_amount    <= it.amount;
    in_if.event_time     <= it.stamp;
    in_if.ignition_level <= it.level;
    in_if.neighbor_mask  <= it.mask;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  // Lets every expected word arrive, then waits out any item still in flight
  // that produces nothing.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Holds the write enable high across consecutive writes; the caller drops it.
  task automatic write_reg(bit [CFG_IDX_W-1:0] reg_idx, bit [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= reg_idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.configure(reg_idx, val);
  endtask

  task automatic set_grid(int w, int h, int growth, int frac, int burn);
    drain();
    write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_GROWTH_RATE, CFG_DATA_W'(growth));
    write_reg(CFG_RADIATED_FRC, CFG_DATA_W'(frac));
    write_reg(CFG_BURNOUT_LVL, CFG_DATA_W'(burn));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    phases_run++;
  endtask

  function automatic cell_item_t load_item(int idx, int amount, int level, int mask);
    return '{load: 1'b1, idx: CELL_IDX_W'(idx), kind: kind_e'($urandom_range(3)),
             amount: AMOUNT_W'(amount), stamp: $urandom, level: LEVEL_W'(level),
             mask: MASK_W'(mask)};
  endfunction

  function automatic cell_item_t event_item(int idx, kind_e kind, int amount, int stamp);
    return '{load: 1'b0, idx: CELL_IDX_W'(idx), kind: kind, amount: AMOUNT_W'(amount),
             stamp: stamp, level: LEVEL_W'($urandom_range(1, 255)),
             mask: MASK_W'($urandom)};
  endfunction

  // Random heat leans small so cells ignite and burn out in a few steps, with
  // full-range values now and then to reach saturation.
  function automatic int rand_heat();
    return ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(400);
  endfunction

  // Random items of one phase: mostly events that the engine itself emitted,
  // replayed toward loaded cells, plus fresh loads, random events on loaded
  // cells and a few items off the grid.
  task automatic random_phase(int count);
    cell_item_t it;
    int sent, pick, tries, idx, area;
    sent = 0;
    area = sb.cols * sb.rows;
    while (sent < count) begin
      pick = $urandom_range(99);
      idx = -1;
      for (tries = 0; tries < 20 && idx < 0; tries++) begin
        idx = $urandom_range(area - 1);
        if (!sb.loaded[idx]) idx = -1;
      end
      if (pick < 20 || idx < 0) begin
        if (area < CELLS && $urandom_range(19) == 0)
          it = load_item($urandom_range(CELLS - 1, area), rand_heat(),
                         $urandom_range(1, 255), $urandom);
        else
          it = load_item($urandom_range(area - 1), rand_heat(),
                         $urandom_range(1, 255), $urandom);
      end else if (pick < 70 && sb.followups.size() != 0) begin
        it = sb.followups.pop_front();
      end else if (area < CELLS && pick >= 96) begin
        it = event_item($urandom_range(CELLS - 1, area), kind_e'($urandom_range(3)),
                        rand_heat(), $urandom);
      end else begin
        it = event_item(idx, kind_e'($urandom_range(3)), rand_heat(), $urandom);
      end
      send_item(it);
      if (it.idx < area) sent++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values of the registers, full 64 by 64 grid.
    random_phase(40);

    // Directed part on a 4 by 4 grid so that wrapped neighbors are loaded.
    set_grid(4, 4, 3, 30000, 100);
    send_item(load_item(0, 0, 255, 8'hFF));        // corner cell, every neighbor linked
    send_item(load_item(5, 65535, 255, 8'h00));    // full heat ignites on load
    send_item(load_item(1, 10, 200, 8'h0F));
    send_item(load_item(4, 0, 1, 8'hF0));          // lowest threshold, still below it
    send_item(load_item(15, 300, 50, 8'h55));
    send_item(load_item(12, 0, 255, 8'hAA));
    send_item(load_item(4095, 7, 9, 8'h01));       // off the grid, ignored
    send_item(event_item(0, K_RAD, 65535, 32'hFFFF_FFFF));  // time wraps on ignition
    send_item(event_item(0, K_IGN, 0, 100));
    send_item(event_item(0, K_PEAK, 0, 200));
    send_item(event_item(0, K_TIMER, 0, 32'hFFFF_FFFE));    // eight neighbors plus rearm
    send_item(event_item(1, K_TIMER, 0, 50));      // heat under burnout, cell burns out
    send_item(event_item(1, K_RAD, 65535, 60));    // burnt cell ignores radiation
    send_item(event_item(12, K_RAD, 100, 70));     // stays below threshold, no result
    send_item(event_item(15, K_TIMER, 0, 80));
    send_item(event_item(5, K_PEAK, 0, 90));       // peak saturates heat
    send_item(event_item(16, K_RAD, 10, 1));       // off the grid, ignored
    random_phase(RANDOM_PER_PHASE);

    // Zero width acts as one column, zero growth as one, nearly all heat radiated.
    set_grid(0, 3, 0, 65535, 0);
    random_phase(RANDOM_PER_PHASE);

    // Width beyond the maximum is clamped; this stretch runs without idling.
    quiet = 1'b1;
    set_grid(127, 1, 65535, 0, 65535);
    random_phase(RANDOM_PER_PHASE);
    quiet = 1'b0;

    set_grid(8, 8, 1, 20000, 5);
    random_phase(RANDOM_PER_PHASE);

    set_grid(64, 64, 200, 50000, 1000);
    random_phase(RANDOM_PER_PHASE);

    drain();
    $display("Run covered %0d items over %0d grid settings; %0d result words checked.",
             items_sent, phases_run + 1, sb.words_checked);
    if (sb.mismatches == 0 && sb.pending_events.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d words never seen", sb.mismatches,
               sb.pending_events.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
